/* rtl/rrts_pkg.sv */
// Shared types and constants for the round-robin task scheduler.
// Used by rrts_ctrl, rrts_dp and round_robin_task_scheduler; no dependencies.
package rrts_pkg;

  localparam int NumSlotsDef   = 5;
  localparam int QueueDepthDef = 8;

  localparam int PidW     = 23;
  localparam int PcW      = 16;
  localparam int OpnW     = 8;
  localparam int CntW     = 16;
  localparam int StW      = 2;
  localparam int DevW     = 2;
  localparam int ActW     = 3;
  localparam int SlotOutW = 3;
  localparam int NumRegs  = 5;
  localparam int CfgIdxW  = 3;

  localparam logic [StW-1:0] ST_READY   = 2'd0;
  localparam logic [StW-1:0] ST_RUNNING = 2'd1;
  localparam logic [StW-1:0] ST_BLOCKED = 2'd2;

  localparam logic [DevW-1:0] DEV_NONE = 2'd0;
  localparam logic [DevW-1:0] DEV_ONE  = 2'd1;
  localparam logic [DevW-1:0] DEV_TWO  = 2'd2;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_DEV1   = 2'd1,
    OP_DEV2   = 2'd2,
    OP_REPORT = 2'd3
  } op_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE     = 3'd0,
    ACT_STOP     = 3'd1,
    ACT_CONTINUE = 3'd2,
    ACT_READY    = 3'd3,
    ACT_OVERFLOW = 3'd4
  } act_e;

  // which slot a result beat reports
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_STOP = 2'd1,
    SEL_IDX  = 2'd2
  } sel_e;

  typedef struct packed {
    logic load;
    logic tick_stop;
    logic scan_step;
    logic rep_commit;
    logic pop_read;
    logic pop_set;
    logic pop_commit;
    logic emit;
    act_e action;
    sel_e sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic stopped;
    logic found;
    logic ovf;
    logic dev_req;
    logic q_empty;
    logic scan_hit;
    logic scan_last;
  } sts_t;

endpackage

/* rtl/rrts_ctrl.sv */
// Sequencer of the round-robin task scheduler.
// Depends on rrts_pkg; drives rrts_dp through cmd_t and reads back sts_t.
module rrts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    op_i,
  output rrts_pkg::cmd_t cmd_o,
  input  rrts_pkg::sts_t sts_i
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TSTOP  = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_RCMT   = 9'b000001000,
    S_POPRD  = 9'b000010000,
    S_POPSET = 9'b000100000,
    S_POPCMT = 9'b001000000,
    S_EMIT1  = 9'b010000000,
    S_EMIT2  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EMIT1;
        end
      end
      default: ;
    endcase
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (rrts_pkg::op_e'(op_i))
            rrts_pkg::OP_TICK:   state_d = S_TSTOP;
            rrts_pkg::OP_REPORT: state_d = S_SCAN;
            default:             state_d = S_POPRD;
          endcase
        end
      end
      S_TSTOP: begin
        cmd_o.tick_stop = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_last) begin
          if (sts_i.op == rrts_pkg::OP_REPORT && sts_i.scan_hit) begin
            state_d = S_RCMT;
          end else begin
            state_d = S_EMIT1;
          end
        end
      end
      S_RCMT: begin
        cmd_o.rep_commit = 1'b1;
        state_d          = S_EMIT1;
      end
      S_POPRD: begin
        if (sts_i.q_empty) begin
          state_d = S_EMIT1;
        end else begin
          cmd_o.pop_read = 1'b1;
          state_d        = S_POPSET;
        end
      end
      S_POPSET: begin
        cmd_o.pop_set = 1'b1;
        state_d       = S_POPCMT;
      end
      S_POPCMT: begin
        cmd_o.pop_commit = 1'b1;
        state_d          = S_EMIT1;
      end
      S_EMIT1: begin
        cmd_o.emit   = 1'b1;
        cmd_o.action = rrts_pkg::ACT_NONE;
        cmd_o.sel    = rrts_pkg::SEL_NONE;
        cmd_o.last   = 1'b1;
        state_d      = S_IDLE;
        case (sts_i.op)
          rrts_pkg::OP_TICK: begin
            if (sts_i.stopped) begin
              cmd_o.action = rrts_pkg::ACT_STOP;
              cmd_o.sel    = rrts_pkg::SEL_STOP;
              cmd_o.last   = !sts_i.found;
              if (sts_i.found) begin
                state_d = S_EMIT2;
              end
            end else if (sts_i.found) begin
              cmd_o.action = rrts_pkg::ACT_CONTINUE;
              cmd_o.sel    = rrts_pkg::SEL_IDX;
            end
          end
          rrts_pkg::OP_REPORT: begin
            if (sts_i.found && sts_i.dev_req) begin
              cmd_o.action = rrts_pkg::ACT_STOP;
              cmd_o.sel    = rrts_pkg::SEL_IDX;
              cmd_o.last   = !sts_i.ovf;
              if (sts_i.ovf) begin
                state_d = S_EMIT2;
              end
            end
          end
          default: begin
            if (sts_i.found) begin
              cmd_o.action = rrts_pkg::ACT_READY;
              cmd_o.sel    = rrts_pkg::SEL_IDX;
            end
          end
        endcase
      end
      S_EMIT2: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = rrts_pkg::SEL_IDX;
        cmd_o.last = 1'b1;
        if (sts_i.op == rrts_pkg::OP_TICK) begin
          cmd_o.action = rrts_pkg::ACT_CONTINUE;
        end else begin
          cmd_o.action = rrts_pkg::ACT_OVERFLOW;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rrts_dp.sv */
// Datapath of the round-robin task scheduler: slot table, scan pointer,
// device wait queues and result register. Depends on rrts_pkg; run by rrts_ctrl.
module rrts_dp #(
  parameter int NUM_SLOTS   = rrts_pkg::NumSlotsDef,
  parameter int QUEUE_DEPTH = rrts_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rrts_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rrts_pkg::PidW-1:0]        cfg_data_i,
  input  logic [1:0]                       op_i,
  input  logic [rrts_pkg::PidW-1:0]        task_pid_i,
  input  logic [rrts_pkg::PcW-1:0]         task_pc_i,
  input  logic [rrts_pkg::DevW-1:0]        task_device_i,
  input  logic [rrts_pkg::StW-1:0]         task_state_i,
  input  logic [rrts_pkg::OpnW-1:0]        task_operation_i,
  input  rrts_pkg::cmd_t                   cmd_i,
  output rrts_pkg::sts_t                   sts_o,
  output logic                             result_valid_o,
  output logic [rrts_pkg::ActW-1:0]        action_o,
  output logic [rrts_pkg::SlotOutW-1:0]    slot_o,
  output logic [rrts_pkg::PidW-1:0]        slot_pid_o,
  output logic                             last_o
);

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QPtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_SLOTS - 1);
  localparam logic [QPtrW-1:0] LastPtr  = QPtrW'(QUEUE_DEPTH - 1);
  localparam logic [QCntW-1:0] FullCnt  = QCntW'(QUEUE_DEPTH);
  localparam logic [QCntW:0]   DepthX   = (QCntW + 1)'(QUEUE_DEPTH);

  // slot table
  logic [rrts_pkg::PidW-1:0] pid_q  [NUM_SLOTS];
  logic [rrts_pkg::StW-1:0]  st_q   [NUM_SLOTS];
  logic [rrts_pkg::DevW-1:0] dev_q  [NUM_SLOTS];
  logic [rrts_pkg::PcW-1:0]  pc_q   [NUM_SLOTS];
  logic [rrts_pkg::OpnW-1:0] opn_q  [NUM_SLOTS];
  logic [rrts_pkg::CntW-1:0] cnt1_q [NUM_SLOTS];
  logic [rrts_pkg::CntW-1:0] cnt2_q [NUM_SLOTS];

  // latched input beat
  rrts_pkg::op_e             op_q;
  logic [rrts_pkg::PidW-1:0] tpid_q;
  logic [rrts_pkg::PcW-1:0]  tpc_q;
  logic [rrts_pkg::DevW-1:0] tdev_q;
  logic [rrts_pkg::StW-1:0]  tst_q;
  logic [rrts_pkg::OpnW-1:0] topn_q;

  logic [SlotW-1:0]          cur_q;
  logic                      cur_vld_q;
  logic [SlotW-1:0]          idx_q;
  logic [SlotW-1:0]          scnt_q;
  logic                      found_q;
  logic                      stopped_q;
  logic                      ovf_q;
  logic [SlotW-1:0]          stop_slot_q;
  logic [rrts_pkg::PidW-1:0] stop_pid_q;

  // wait queues
  logic [SlotW-1:0] q1_mem [QUEUE_DEPTH];
  logic [SlotW-1:0] q2_mem [QUEUE_DEPTH];
  logic [QPtrW-1:0] head_q [2];
  logic [QCntW-1:0] qcnt_q [2];
  logic [SlotW-1:0] rdata_q;

  logic                      res_valid_q;
  logic [rrts_pkg::ActW-1:0] res_act_q;
  logic [SlotW-1:0]          res_slot_q;
  logic [rrts_pkg::PidW-1:0] res_pid_q;
  logic                      res_last_q;

  logic [SlotW-1:0]          idx_next;
  logic                      hit;
  logic                      qsel_pop;
  logic                      qsel_push;
  logic                      push_full;
  logic [QCntW:0]            push_sum;
  logic [QPtrW-1:0]          push_addr;
  logic                      push_en;

  assign idx_next = (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
  assign hit = (op_q == rrts_pkg::OP_TICK) ? (st_q[idx_q] == rrts_pkg::ST_READY)
                                           : (pid_q[idx_q] == tpid_q);

  assign qsel_pop  = (op_q == rrts_pkg::OP_DEV2);
  assign qsel_push = (tdev_q == rrts_pkg::DEV_TWO);
  assign push_full = (qcnt_q[qsel_push] == FullCnt);
  assign push_sum  = (QCntW + 1)'(head_q[qsel_push]) + (QCntW + 1)'(qcnt_q[qsel_push]);
  assign push_addr = (push_sum >= DepthX) ? QPtrW'(push_sum - DepthX) : QPtrW'(push_sum);
  assign push_en   = cmd_i.rep_commit && (tdev_q != rrts_pkg::DEV_NONE) && !push_full;

  always_comb begin
    sts_o           = '0;
    sts_o.op        = op_q;
    sts_o.stopped   = stopped_q;
    sts_o.found     = found_q;
    sts_o.ovf       = ovf_q;
    sts_o.dev_req   = (tdev_q != rrts_pkg::DEV_NONE);
    sts_o.q_empty   = (qcnt_q[qsel_pop] == '0);
    sts_o.scan_hit  = hit;
    sts_o.scan_last = (scnt_q == LastSlot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pid_q[i]  <= '0;
        st_q[i]   <= rrts_pkg::ST_READY;
        dev_q[i]  <= rrts_pkg::DEV_NONE;
        pc_q[i]   <= '0;
        opn_q[i]  <= '0;
        cnt1_q[i] <= '0;
        cnt2_q[i] <= '0;
      end
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      scnt_q    <= '0;
      found_q   <= 1'b0;
      stopped_q <= 1'b0;
      ovf_q     <= 1'b0;
      op_q      <= rrts_pkg::OP_TICK;
      tdev_q    <= rrts_pkg::DEV_NONE;
      for (int q = 0; q < 2; q++) begin
        head_q[q] <= '0;
        qcnt_q[q] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (i < rrts_pkg::NumRegs && int'(cfg_idx_i) == i) begin
            pid_q[i] <= cfg_data_i;
          end
        end
      end

      if (cmd_i.load) begin
        op_q      <= rrts_pkg::op_e'(op_i);
        tdev_q    <= (task_device_i == 2'd3) ? rrts_pkg::DEV_TWO : task_device_i;
        idx_q     <= (rrts_pkg::op_e'(op_i) == rrts_pkg::OP_TICK && cur_vld_q) ? cur_q : '0;
        scnt_q    <= '0;
        found_q   <= 1'b0;
        stopped_q <= 1'b0;
        ovf_q     <= 1'b0;
      end

      if (cmd_i.tick_stop) begin
        if (cur_vld_q) begin
          idx_q <= idx_next;
          if (st_q[idx_q] == rrts_pkg::ST_RUNNING) begin
            stopped_q   <= 1'b1;
            st_q[idx_q] <= rrts_pkg::ST_READY;
          end
        end
      end

      if (cmd_i.scan_step) begin
        if (hit) begin
          found_q <= 1'b1;
          if (op_q == rrts_pkg::OP_TICK) begin
            st_q[idx_q] <= rrts_pkg::ST_RUNNING;
            cur_q       <= idx_q;
            cur_vld_q   <= 1'b1;
          end
        end else begin
          idx_q  <= idx_next;
          scnt_q <= scnt_q + 1'b1;
        end
      end

      if (cmd_i.rep_commit) begin
        dev_q[idx_q] <= tdev_q;
        pc_q[idx_q]  <= tpc_q;
        st_q[idx_q]  <= tst_q;
        opn_q[idx_q] <= topn_q;
        if (tdev_q == rrts_pkg::DEV_ONE && cnt1_q[idx_q] != rrts_pkg::CNT_MAX) begin
          cnt1_q[idx_q] <= cnt1_q[idx_q] + 1'b1;
        end
        if (tdev_q == rrts_pkg::DEV_TWO && cnt2_q[idx_q] != rrts_pkg::CNT_MAX) begin
          cnt2_q[idx_q] <= cnt2_q[idx_q] + 1'b1;
        end
        if (tdev_q != rrts_pkg::DEV_NONE) begin
          if (push_full) begin
            ovf_q <= 1'b1;
          end else begin
            qcnt_q[qsel_push] <= qcnt_q[qsel_push] + 1'b1;
          end
        end
      end

      if (cmd_i.pop_read) begin
        head_q[qsel_pop] <= (head_q[qsel_pop] == LastPtr) ? '0 : head_q[qsel_pop] + 1'b1;
        qcnt_q[qsel_pop] <= qcnt_q[qsel_pop] - 1'b1;
      end

      if (cmd_i.pop_set) begin
        idx_q <= rdata_q;
      end

      if (cmd_i.pop_commit) begin
        st_q[idx_q]  <= rrts_pkg::ST_READY;
        dev_q[idx_q] <= rrts_pkg::DEV_NONE;
        opn_q[idx_q] <= '0;
        found_q      <= 1'b1;
      end
    end
  end

  // payload of the input beat, and the slot index and pid seen at a tick's stop check
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tpid_q <= task_pid_i;
      tpc_q  <= task_pc_i;
      tst_q  <= (task_state_i == 2'd3) ? rrts_pkg::ST_BLOCKED : task_state_i;
      topn_q <= task_operation_i;
    end
    if (cmd_i.tick_stop) begin
      stop_slot_q <= idx_q;
      stop_pid_q  <= pid_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en && !qsel_push) begin
      q1_mem[push_addr] <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en && qsel_push) begin
      q2_mem[push_addr] <= idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_read) begin
      rdata_q <= qsel_pop ? q2_mem[head_q[1]] : q1_mem[head_q[0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_act_q  <= cmd_i.action;
      res_last_q <= cmd_i.last;
      case (cmd_i.sel)
        rrts_pkg::SEL_STOP: begin
          res_slot_q <= stop_slot_q;
          res_pid_q  <= stop_pid_q;
        end
        rrts_pkg::SEL_IDX: begin
          res_slot_q <= idx_q;
          res_pid_q  <= pid_q[idx_q];
        end
        default: begin
          res_slot_q <= '0;
          res_pid_q  <= '0;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign action_o       = res_act_q;
  assign slot_o         = rrts_pkg::SlotOutW'(res_slot_q);
  assign slot_pid_o     = res_pid_q;
  assign last_o         = res_last_q;

endmodule

/* rtl/round_robin_task_scheduler.sv */
// Round-robin task scheduler: five-slot (NUM_SLOTS) scheduler with two
// device wait queues. Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// Usage:
//   An event beat is taken at a rising edge with start high and busy low;
//   op_i selects time-slice tick, device one done, device two done or task
//   report, and the task_* ports carry the report fields.
//   Each event gives one or two result beats on action_o, slot_o, slot_pid_o,
//   each shown for one cycle with result_valid_o high; last_o marks the final
//   beat of the event. An event with no effect gives one beat with action none.
//   The receiver cannot hold results off; the block never waits on it.
//   Slot process ids are written through cfg_we_i/cfg_idx_i/cfg_data_i, register i for
//   slot i; the user writes them only while busy is low, as the block does not enforce it.
// Timing:
//   One event at a time. A tick or report walks the slot table one slot per
//   cycle; a device-done event pops its queue (the queue memory read is
//   registered), then marks the popped slot ready.
//   busy drops while the last result beat is on the ports.
// Reset: all slots ready with zero fields, no current slot, queues empty, pids zero.
module round_robin_task_scheduler #(
  parameter int NUM_SLOTS   = rrts_pkg::NumSlotsDef,
  parameter int QUEUE_DEPTH = rrts_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rrts_pkg::PidW-1:0]     cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic [rrts_pkg::PidW-1:0]     task_pid_i,
  input  logic [rrts_pkg::PcW-1:0]      task_pc_i,
  input  logic [rrts_pkg::DevW-1:0]     task_device_i,
  input  logic [rrts_pkg::StW-1:0]      task_state_i,
  input  logic [rrts_pkg::OpnW-1:0]     task_operation_i,
  output logic                          result_valid_o,
  output logic [rrts_pkg::ActW-1:0]     action_o,
  output logic [rrts_pkg::SlotOutW-1:0] slot_o,
  output logic [rrts_pkg::PidW-1:0]     slot_pid_o,
  output logic                          last_o
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .op_i   (op_i),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  rrts_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .task_pid_i       (task_pid_i),
    .task_pc_i        (task_pc_i),
    .task_device_i    (task_device_i),
    .task_state_i     (task_state_i),
    .task_operation_i (task_operation_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_valid_o   (result_valid_o),
    .action_o         (action_o),
    .slot_o           (slot_o),
    .slot_pid_o       (slot_pid_o),
    .last_o           (last_o)
  );

endmodule
